// ===== hw/rtl/potts_pkg.sv =====
// ----------------------------------------------------------------------------
// potts_pkg
// Shared types and constants for the periodic / one-shot tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package potts_pkg;

  // default number of slots in the table
  localparam int SLOTS_DEFAULT = 8;

  // width of the time count used for wrap-around
  localparam int TICK_BITS = 32;

  localparam int DUE_W  = 8;
  localparam int IDX_W  = 3;
  localparam int TIME_W = 32;

  // mask that reduces a 32-bit difference modulo 2^TICK_BITS
  localparam logic [TIME_W-1:0] TIME_MASK = (TICK_BITS >= TIME_W) ? {TIME_W{1'b1}} :
      TIME_W'((64'd1 << TICK_BITS) - 64'd1);

  typedef enum logic [1:0] {
    OP_ATTACH = 2'd0,
    OP_TICK   = 2'd1,
    OP_SET    = 2'd2
  } op_t;

  // command token walking along the cell row
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [TIME_W-1:0] ival;
    logic              shot;
    logic [TIME_W-1:0] now;
    logic [DUE_W-1:0]  due;
  } tok_t;

  // one result item
  typedef struct packed {
    logic [DUE_W-1:0] due;
    logic [IDX_W-1:0] idx;
    logic             err;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/potts_req_if.sv =====
// ----------------------------------------------------------------------------
// potts_req_if
// Request channel: operation item with valid / ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface potts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] interval;
  logic        one_shot;
  logic [2:0]  slot_select;
  logic [31:0] tick_time;

  modport source (output valid, operation, interval, one_shot, slot_select, tick_time,
                  input ready);
  modport sink   (input valid, operation, interval, one_shot, slot_select, tick_time,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/potts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// potts_rsp_if
// Response channel: result item with valid / ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface potts_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] due_mask;
  logic [2:0] slot_index;
  logic       error;

  modport source (output valid, due_mask, slot_index, error, input ready);
  modport sink   (input valid, due_mask, slot_index, error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/potts_cell.sv =====
// ----------------------------------------------------------------------------
// potts_cell
// One timer slot: holds its state and acts on the token passing through.
// ----------------------------------------------------------------------------
`default_nettype none

module potts_cell
  import potts_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t tok_in,
  input  wire logic used,
  input  wire logic hit,
  output tok_t      tok_out
);

  localparam logic [IDX_W-1:0] DUE_BIT = IDX_W'(IDX % DUE_W);

  logic [TIME_W-1:0] interval;
  logic [TIME_W-1:0] last_fire;
  logic [TIME_W-1:0] seen_time;
  logic              one_shot;
  logic              fired_once;

  logic [TIME_W-1:0] diff;
  logic              every_tick;
  logic              qualify;
  logic              fire;
  tok_t              tok_next;

  always_comb begin
    diff       = (tok_in.now - last_fire) & TIME_MASK;
    every_tick = (interval == TIME_W'(1));
    qualify    = tok_in.valid && (tok_in.op == OP_TICK) && used &&
                 (every_tick || (diff == interval));
    fire       = qualify && (!one_shot || !fired_once);
    tok_next   = tok_in;
    if (fire && (IDX < DUE_W)) begin
      tok_next.due[DUE_BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    // token payload and slot state
    tok_out.op   <= tok_next.op;
    tok_out.ival <= tok_next.ival;
    tok_out.shot <= tok_next.shot;
    tok_out.now  <= tok_next.now;
    tok_out.due  <= tok_next.due;
    if (tok_in.valid && hit && (tok_in.op == OP_ATTACH)) begin
      interval  <= tok_in.ival;
      last_fire <= '0;
      one_shot  <= tok_in.shot;
    end else if (tok_in.valid && hit && (tok_in.op == OP_SET)) begin
      interval  <= tok_in.ival;
      last_fire <= seen_time;
    end else if (qualify && !every_tick) begin
      last_fire <= tok_in.now;
    end
    // control-like bits: cleared at reset
    if (rst) begin
      tok_out.valid <= 1'b0;
      seen_time     <= '0;
      fired_once    <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
      if (tok_in.valid && (tok_in.op == OP_TICK) && used && !every_tick) begin
        seen_time <= tok_in.now;
      end
      if (qualify && one_shot) begin
        fired_once <= 1'b1;
      end
      if (tok_in.valid && hit && (tok_in.op == OP_ATTACH)) begin
        fired_once <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_oneshot_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_oneshot_task_tick_scheduler
// Slot table of periodic and one-shot task timers built as a row of cells.
// ----------------------------------------------------------------------------
// usage
//   req: one item per transfer; operation picks attach, tick or set interval
//   rsp: exactly one result per request (due mask, slot index, error flag)
//   each slot lives in its own cell; a command token enters cell 0 and moves
//   one cell per cycle, every cell acting on it as it passes
//   path: entry register tok[0], each cell's register, then the output register
//   a new request is taken only once the token has left the row;
//   req.ready stays low while a token is on the row
//   a finished result sits in the output register; a second one can park in
//   a skid register, so a stalled receiver blocks new requests only once
//   both are full
//   reset: empties the table (slot count zero), clears seen times and
//   fired flags, drops any token and any pending result
//   unknown operation codes pass the row without effect and answer zeros
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_oneshot_task_tick_scheduler
  import potts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  potts_req_if.sink     req,
  potts_rsp_if.source   rsp
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  // token stages: tok[i] feeds cell i, tok[SLOTS] leaves the row
  tok_t tok [SLOTS+1];

  logic [CNT_W-1:0] slots_used;
  logic [SLOTS-1:0] hit;        // per-cell target of attach / set interval
  logic [SLOTS-1:0] hit_next;
  logic [SLOTS-1:0] used;
  logic             busy;
  logic [IDX_W-1:0] idx_q;
  logic             err_q;
  logic [IDX_W-1:0] idx_next;
  logic             err_next;
  logic             table_full;
  logic             sel_ok;

  res_t out_q;
  logic out_valid;
  res_t skid_q;
  logic skid_valid;
  res_t row_res;
  logic row_done;
  logic req_fire;
  logic rsp_fire;

  assign req.ready = !busy && !skid_valid;
  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = rsp.valid && rsp.ready;

  assign table_full = (slots_used == CNT_W'(SLOTS));
  assign sel_ok     = (int'(req.slot_select) < int'(slots_used));

  // decode the request into per-cell strobes and the answer fields
  always_comb begin
    hit_next = '0;
    idx_next = '0;
    err_next = 1'b0;
    unique case (req.operation)
      OP_ATTACH: begin
        if (table_full) begin
          err_next = 1'b1;
        end else begin
          idx_next = IDX_W'(slots_used);
          for (int i = 0; i < SLOTS; i++) begin
            hit_next[i] = (int'(slots_used) == i);
          end
        end
      end
      OP_SET: begin
        if (!sel_ok) begin
          err_next = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            hit_next[i] = (int'(req.slot_select) == i);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // occupancy seen by a tick walking the row
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      used[i] = (i < int'(slots_used));
    end
  end

  // token entry and table count
  always_ff @(posedge clk) begin
    if (req_fire) begin
      // unknown codes enter as an attach that hits no cell
      tok[0].op <= (req.operation == OP_TICK) ? OP_TICK :
                   (req.operation == OP_SET)  ? OP_SET  : OP_ATTACH;
      tok[0].ival <= req.interval;
      tok[0].shot <= req.one_shot;
      tok[0].now  <= req.tick_time;
      tok[0].due  <= '0;
      hit         <= hit_next;
      idx_q       <= idx_next;
      err_q       <= err_next;
    end
    if (rst) begin
      tok[0].valid <= 1'b0;
      slots_used   <= '0;
      busy         <= 1'b0;
    end else begin
      tok[0].valid <= req_fire;
      if (req_fire) begin
        busy <= 1'b1;
      end else if (row_done) begin
        busy <= 1'b0;
      end
      if (req_fire && (req.operation == OP_ATTACH) && !table_full) begin
        slots_used <= slots_used + CNT_W'(1);
      end
    end
  end

  // row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    potts_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .used    (used[g]),
      .hit     (hit[g]),
      .tok_out (tok[g+1])
    );
  end

  assign row_done    = tok[SLOTS].valid;
  assign row_res.due = tok[SLOTS].due;
  assign row_res.idx = idx_q;
  assign row_res.err = err_q;

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (row_done) begin
        if (!out_valid || rsp_fire) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (rsp_fire) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_done) begin
      if (!out_valid || rsp_fire) begin
        out_q <= row_res;
      end else begin
        skid_q <= row_res;
      end
    end else if (rsp_fire && skid_valid) begin
      out_q <= skid_q;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.due_mask   = out_q.due;
  assign rsp.slot_index = out_q.idx;
  assign rsp.error      = out_q.err;

endmodule

`default_nettype wire

// ===== hw/rtl/potts_checker.sv =====
// ----------------------------------------------------------------------------
// potts_checker
// Port-level checks for the tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module potts_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] due_mask,
  input wire logic [2:0] slot_index,
  input wire logic       error
);

  // one item at a time: no back-to-back request transfers
  a_req_spacing: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous item in flight");

  // an error result carries a zero due mask and slot index zero
  a_due_no_err: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> due_mask == 8'd0 && slot_index == 3'd0)
    else $error("error result carries due mask or slot index");

  a_idx_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && slot_index != 3'd0 |-> due_mask == 8'd0)
    else $error("attach result carries a due mask");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(due_mask) && $stable(slot_index) && $stable(error))
    else $error("result changed while stalled");

endmodule

bind periodic_oneshot_task_tick_scheduler potts_checker u_potts_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .due_mask   (rsp.due_mask),
  .slot_index (rsp.slot_index),
  .error      (rsp.error)
);

`default_nettype wire
